// ===== src/md5d_pkg.sv =====
// Shared types, constants and round tables of the MD5 digest engine.
`default_nettype none

package md5d_pkg;

    typedef enum logic [1:0] {
        ACT_ABSORB        = 2'd0,
        ACT_ABSORB_FINISH = 2'd1,
        ACT_FINISH        = 2'd2,
        ACT_NONE          = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic start;
        logic init;
    } cmp_ctl_t;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'h3F;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Index is {quarter, round[1:0]}.
    function automatic logic [4:0] rot_amt(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] g;
        r = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = r;
            2'd1:    g = r * 4'd5 + 4'd1;
            2'd2:    g = r * 4'd3 + 4'd5;
            default: g = r * 4'd7;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== src/md5d_in_if.sv =====
// Input channel: one message byte and its action per transaction.
`default_nettype none

interface md5d_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/md5d_out_if.sv =====
// Output channel: one digest word per transaction.
`default_nettype none

interface md5d_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

// ===== src/md5d_front.sv =====
// Front end: accepts input transactions, drops meaningless actions, queues the rest.
`default_nettype none

module md5d_front #(
    parameter int unsigned QueueDepth = md5d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  md5d_pkg::item_t in_item,
    output logic            item_valid,
    input  logic            item_ready,
    output md5d_pkg::item_t item
);
    import md5d_pkg::*;

    localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CW = $clog2(QueueDepth + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QueueDepth - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QueueDepth);

    item_t         queue_reg [QueueDepth];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready   = (count_reg != FULL_CNT);
    assign item_valid = (count_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];

    // Action code 3 is consumed here and never reaches the back end.
    assign push = in_valid && in_ready && (in_item.action != ACT_NONE);
    assign pop  = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/md5d_compress.sv =====
// Iterative MD5 compression unit: one round per cycle, owns the chaining words.
`default_nettype none

module md5d_compress (
    input  logic               clk,
    input  logic               rst_n,
    input  md5d_pkg::cmp_ctl_t ctl,
    output logic               done,
    output logic [3:0]         msg_idx,
    input  logic [31:0]        msg_word,
    output logic [31:0]        chain [4]
);
    import md5d_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_PREP, C_RUN, C_ADD} cstate_t;

    cstate_t     state_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] kw_reg;
    logic [31:0] chain_reg [4];

    logic [5:0]  nxt_rnd;
    logic [31:0] kw_calc;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [31:0] nb;

    assign done  = (state_reg == C_ADD);
    assign chain = chain_reg;

    // Fetch constant plus message word one round ahead.
    assign nxt_rnd = (state_reg == C_PREP) ? 6'd0 : rnd_reg + 6'd1;
    assign msg_idx = msg_index(nxt_rnd);
    assign kw_calc = round_k(nxt_rnd) + msg_word;

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1:    f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign sum = a_reg + f_val + kw_reg;
    assign nb  = b_reg + rotl(sum, rot_amt({rnd_reg[5:4], rnd_reg[1:0]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            rnd_reg      <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
            d_reg        <= '0;
            kw_reg       <= '0;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (ctl.init)
                    begin
                        chain_reg[0] <= IV_A;
                        chain_reg[1] <= IV_B;
                        chain_reg[2] <= IV_C;
                        chain_reg[3] <= IV_D;
                    end
                    if (ctl.start)
                    begin
                        state_reg <= C_PREP;
                    end
                end
                C_PREP:
                begin
                    a_reg     <= chain_reg[0];
                    b_reg     <= chain_reg[1];
                    c_reg     <= chain_reg[2];
                    d_reg     <= chain_reg[3];
                    kw_reg    <= kw_calc;
                    rnd_reg   <= '0;
                    state_reg <= C_RUN;
                end
                C_RUN:
                begin
                    a_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= b_reg;
                    b_reg   <= nb;
                    kw_reg  <= kw_calc;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == LAST_POS)
                    begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    state_reg    <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/md5d_back.sv =====
// Back end: packs bytes into the block, pads on finish, sequences compression, emits the digest.
`default_nettype none

module md5d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  md5d_pkg::item_t    item,
    output md5d_pkg::cmp_ctl_t cmp_ctl,
    input  logic               cmp_done,
    input  logic [3:0]         msg_idx,
    output logic [31:0]        msg_word,
    input  logic [31:0]        chain [4],
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        digest_word,
    output logic [1:0]         word_index,
    output logic               last_word
);
    import md5d_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_AWAIT, B_PAD, B_XWAIT, B_FWAIT, B_OUT
    } bstate_t;

    bstate_t     state_reg, state_next;
    logic [31:0] total_reg, total_next;
    logic        fin_pend_reg, fin_pend_next;
    logic [1:0]  wcnt_reg, wcnt_next;
    logic        start_reg, start_next;
    logic        init_reg, init_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;

    logic [31:0] blk_reg  [16];
    logic [31:0] blk_next [16];
    logic [31:0] pad_word [16];

    logic [5:0]  pos;
    logic [3:0]  wsel;
    logic [1:0]  lane;

    assign pos  = total_reg[5:0];
    assign wsel = pos[5:2];
    assign lane = pos[1:0];

    assign item_ready    = (state_reg == B_IDLE);
    assign msg_word      = blk_reg[msg_idx];
    assign cmp_ctl.start = start_reg;
    assign cmp_ctl.init  = init_reg;
    assign out_valid     = out_valid_reg;
    assign digest_word   = out_word_reg;
    assign word_index    = out_idx_reg;
    assign last_word     = out_last_reg;

    // Padded block: keep bytes below the current position, 0x80 there, zero above.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            pad_word[i] = blk_reg[i];
            if (4'(i) > wsel)
            begin
                pad_word[i] = '0;
            end
            else if (4'(i) == wsel)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (2'(j) == lane)
                    begin
                        pad_word[i][j*8 +: 8] = PAD_BYTE;
                    end
                    else if (2'(j) > lane)
                    begin
                        pad_word[i][j*8 +: 8] = 8'h00;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        fin_pend_next  = fin_pend_reg;
        wcnt_next      = wcnt_reg;
        start_next     = 1'b0;
        init_next      = 1'b0;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        blk_next       = blk_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.action)
                        ACT_ABSORB, ACT_ABSORB_FINISH:
                        begin
                            blk_next[wsel][{lane, 3'b000} +: 8] = item.data_byte;
                            total_next = total_reg + 32'd1;
                            if (pos == LAST_POS)
                            begin
                                start_next    = 1'b1;
                                fin_pend_next = (item.action == ACT_ABSORB_FINISH);
                                state_next    = B_AWAIT;
                            end
                            else if (item.action == ACT_ABSORB_FINISH)
                            begin
                                state_next = B_PAD;
                            end
                        end
                        ACT_FINISH:
                        begin
                            state_next = B_PAD;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_AWAIT:
            begin
                if (cmp_done)
                begin
                    state_next = fin_pend_reg ? B_PAD : B_IDLE;
                end
            end
            B_PAD:
            begin
                blk_next   = pad_word;
                start_next = 1'b1;
                // No room for the length word: compress this block, then a length-only one.
                if (pos[5:3] == 3'b111)
                begin
                    state_next = B_XWAIT;
                end
                else
                begin
                    blk_next[15] = total_reg;
                    state_next   = B_FWAIT;
                end
            end
            B_XWAIT:
            begin
                if (cmp_done)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        blk_next[i] = '0;
                    end
                    blk_next[15] = total_reg;
                    start_next   = 1'b1;
                    state_next   = B_FWAIT;
                end
            end
            B_FWAIT:
            begin
                if (cmp_done)
                begin
                    wcnt_next  = 2'd0;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain[wcnt_reg];
                    out_idx_next   = wcnt_reg;
                    out_last_next  = (wcnt_reg == 2'd3);
                    wcnt_next      = wcnt_reg + 2'd1;
                    if (wcnt_reg == 2'd3)
                    begin
                        init_next  = 1'b1;
                        total_next = '0;
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            total_reg     <= '0;
            fin_pend_reg  <= 1'b0;
            wcnt_reg      <= '0;
            start_reg     <= 1'b0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            fin_pend_reg  <= fin_pend_next;
            wcnt_reg      <= wcnt_next;
            start_reg     <= start_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            out_idx_reg   <= out_idx_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

`default_nettype wire

// ===== src/md5_digest_engine.sv =====
// MD5 digest engine (byte-stream input, byte-count length field): the top level.
// Message bytes arrive one per transaction on in_ch and are packed little-endian into a
// 64-byte block; a short input queue (QueueDepth entries) takes bytes while the back end
// is busy. A byte that completes a block starts the round unit, which does one MD5 round
// per cycle; that byte holds the back end through accept, start, load, 64 rounds and the
// chain update, and the back end takes no further byte before the chain update is done.
// A finish pads the block, compresses it (plus one extra block when the position is 56 or
// more), and then delivers the four chaining words on out_ch, low word first, last_word
// set on the fourth; the engine then starts a fresh message. The length word is the byte
// count modulo 2^32 in word 15, with word 14 zero. Action 3 is discarded.
`default_nettype none

module md5_digest_engine #(
    parameter int unsigned QueueDepth = md5d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    md5d_in_if.sink     in_ch,
    md5d_out_if.source  out_ch
);
    import md5d_pkg::*;

    item_t       in_item;
    item_t       q_item;
    logic        q_valid;
    logic        q_ready;
    cmp_ctl_t    cmp_ctl;
    logic        cmp_done;
    logic [3:0]  msg_idx;
    logic [31:0] msg_word;
    logic [31:0] chain [4];

    assign in_item.action    = action_t'(in_ch.action);
    assign in_item.data_byte = in_ch.data_byte;

    md5d_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item)
    );

    md5d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .cmp_ctl     (cmp_ctl),
        .cmp_done    (cmp_done),
        .msg_idx     (msg_idx),
        .msg_word    (msg_word),
        .chain       (chain),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .digest_word (out_ch.digest_word),
        .word_index  (out_ch.word_index),
        .last_word   (out_ch.last_word)
    );

    md5d_compress u_compress (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cmp_ctl),
        .done     (cmp_done),
        .msg_idx  (msg_idx),
        .msg_word (msg_word),
        .chain    (chain)
    );

endmodule

`default_nettype wire
